// ===== src/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// shared constants for the sample covariance engine
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int unsigned ASSETS_MAX_DEF  = 4;
  localparam int unsigned SAMPLES_MAX_DEF = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 24;

  localparam int unsigned ACC_W   = 64;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned NA_W    = 3;
  localparam int unsigned NS_W    = 9;

  localparam logic CFG_ASSET_CNT   = 1'b0;
  localparam logic CFG_NUM_SAMPLES = 1'b1;

  localparam logic [NA_W-1:0] ASSET_CNT_RST   = NA_W'(4);
  localparam logic [NS_W-1:0] NUM_SAMPLES_RST = NS_W'(256);

  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_COV  = 1'b1;

endpackage

// ===== src/sce_ram.sv =====
// ----------------------------------------------------------------------------
// sce_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module sce_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== src/sce_div.sv =====
// ----------------------------------------------------------------------------
// sce_div
// signed 64-bit by unsigned divisor, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module sce_div #(
  parameter int unsigned DEN_W = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sce_pkg::ACC_W-1:0] num_i,
  input  logic [DEN_W-1:0]          den_i,
  output logic                      done_o,
  output logic [sce_pkg::ACC_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(sce_pkg::ACC_W + 1);

  logic                      busy_q, busy_d;
  logic                      neg_q, neg_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [DEN_W:0]            rem_q, rem_d;
  logic [sce_pkg::ACC_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]          den_q, den_d;
  logic                      done_q, done_d;
  logic [DEN_W:0]            rem_sh;
  logic                      fits;

  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[sce_pkg::ACC_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[sce_pkg::ACC_W-1];
      quo_d  = num_i[sce_pkg::ACC_W-1] ? (~num_i + 1'b1) : num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[sce_pkg::ACC_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(sce_pkg::ACC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a running division");
`endif

endmodule

// ===== src/sample_covariance_engine.sv =====
// ----------------------------------------------------------------------------
// sample_covariance_engine
// sample means and sample covariance matrix of a loaded return matrix
// ----------------------------------------------------------------------------
// input channel: one return element per request, tagged with asset and
// sample index; elements outside ASSETS_MAX x SAMPLES_MAX are dropped.
// loading accepts elements only while idle. a request with last_item set is
// stored, then the engine runs and holds in_stall_o high until done.
// output channel: one mean per asset in use (Q1.22 sign extended), then the
// squared asset count of covariances in row-major order (Q.44); last_result
// marks the final covariance. each result makes one pass per sample through
// the shared multiply-accumulate (address, center, multiply, add), then runs
// through the bit-serial divider and an emit step, so a full run gives
// na*(1+na) results. an output register sits between the engine and the
// receiver; while it is stalled the sequencer waits in its emit step and
// nothing is lost. configuration writes are plain writes
// (index 0 asset count, index 1 num_samples) and must be done while idle.
// reset clears control state and sets 4 assets, num_samples 256;
// sample contents are undefined until written.
// ----------------------------------------------------------------------------
module sample_covariance_engine #(
  parameter int unsigned ASSETS_MAX  = sce_pkg::ASSETS_MAX_DEF,
  parameter int unsigned SAMPLES_MAX = sce_pkg::SAMPLES_MAX_DEF,
  parameter int unsigned VALUE_WIDTH = sce_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [sce_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 asset_index_i,
  input  logic [7:0]                 sample_index_i,
  input  logic [VALUE_WIDTH-1:0]     return_value_i,
  input  logic                       last_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       result_kind_o,
  output logic [1:0]                 row_index_o,
  output logic [1:0]                 col_index_o,
  output logic [sce_pkg::ACC_W-1:0]  result_value_o,
  output logic                       last_result_o
);

  localparam int unsigned DEPTH  = ASSETS_MAX * SAMPLES_MAX;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IW     = $clog2(ASSETS_MAX);
  localparam int unsigned TW     = $clog2(SAMPLES_MAX);
  localparam int unsigned NSW    = $clog2(SAMPLES_MAX + 1);
  localparam int unsigned CW     = VALUE_WIDTH + 1;
  localparam int unsigned PW     = 2 * CW;
  localparam int unsigned AW     = sce_pkg::ACC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CEN   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DWAIT = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [sce_pkg::NA_W-1:0]   asset_cnt_q;
  logic [sce_pkg::NS_W-1:0]   num_samples_q;
  logic [IW-1:0]              i_q, i_d, j_q, j_d;
  logic [TW-1:0]              t_q, t_d;
  logic                       cov_q, cov_d;
  logic [AW-1:0]              acc_q, acc_d;
  logic signed [CW-1:0]       ci_q, cj_q;
  logic signed [PW-1:0]       prod_q;
  logic [AW-1:0]              res_q;
  logic                       out_valid_q;
  logic                       kind_q, last_q;
  logic [1:0]                 row_q, col_q;
  logic [AW-1:0]              value_q;

  logic [sce_pkg::NA_W-1:0]   na;
  logic [NSW-1:0]             ns;
  logic                       in_fire, in_ok, out_free, emit_fire;
  logic                       i_last, j_last, t_last;
  logic [ADDR_W-1:0]          waddr, raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0]     rd_a, rd_b, mean_a, mean_b;
  logic signed [CW-1:0]       xa, xb, ma, mb;
  logic                       div_done;
  logic [AW-1:0]              div_quot;
  logic [NSW-1:0]             div_den;

  // clamped configuration
  always_comb begin
    if (asset_cnt_q == '0) begin
      na = sce_pkg::NA_W'(1);
    end else if (32'(asset_cnt_q) > ASSETS_MAX) begin
      na = sce_pkg::NA_W'(ASSETS_MAX);
    end else begin
      na = asset_cnt_q;
    end
    if (32'(num_samples_q) < 2) begin
      ns = NSW'(2);
    end else if (32'(num_samples_q) > SAMPLES_MAX) begin
      ns = NSW'(SAMPLES_MAX);
    end else begin
      ns = NSW'(num_samples_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asset_cnt_q   <= sce_pkg::ASSET_CNT_RST;
      num_samples_q <= sce_pkg::NUM_SAMPLES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sce_pkg::CFG_ASSET_CNT:   asset_cnt_q   <= cfg_data_i[sce_pkg::NA_W-1:0];
        sce_pkg::CFG_NUM_SAMPLES: num_samples_q <= cfg_data_i[sce_pkg::NS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_ok      = (32'(asset_index_i) < ASSETS_MAX) && (32'(sample_index_i) < SAMPLES_MAX);
  assign waddr      = ADDR_W'(ADDR_W'(asset_index_i) * ADDR_W'(SAMPLES_MAX))
                    + ADDR_W'(sample_index_i);
  assign raddr_a    = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(SAMPLES_MAX)) + ADDR_W'(t_q);
  assign raddr_b    = ADDR_W'(ADDR_W'(j_q) * ADDR_W'(SAMPLES_MAX)) + ADDR_W'(t_q);

  sce_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_sample_ram (
    .clk_i     (clk_i),
    .we_i      (in_fire && in_ok),
    .waddr_i   (waddr),
    .wdata_i   (return_value_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_fire = (state_q == S_EMIT) && out_free;

  sce_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ASSETS_MAX)
  ) u_mean_ram (
    .clk_i     (clk_i),
    .we_i      (emit_fire && !cov_q),
    .waddr_i   (i_q),
    .wdata_i   (res_q[VALUE_WIDTH-1:0]),
    .raddr_a_i (i_q),
    .raddr_b_i (j_q),
    .rdata_a_o (mean_a),
    .rdata_b_o (mean_b)
  );

  assign div_den = cov_q ? (ns - 1'b1) : ns;

  sce_div #(
    .DEN_W (NSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV),
    .num_i   (acc_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign xa = $signed({rd_a[VALUE_WIDTH-1], rd_a});
  assign xb = $signed({rd_b[VALUE_WIDTH-1], rd_b});
  assign ma = $signed({mean_a[VALUE_WIDTH-1], mean_a});
  assign mb = $signed({mean_b[VALUE_WIDTH-1], mean_b});

  assign i_last = ({{(sce_pkg::NA_W - IW){1'b0}}, i_q} == na - 1'b1);
  assign j_last = ({{(sce_pkg::NA_W - IW){1'b0}}, j_q} == na - 1'b1);
  assign t_last = (NSW'(t_q) == ns - 1'b1);

  // sequencer: means walk row i against 1, covariances walk rows i and j
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    t_d     = t_q;
    cov_d   = cov_q;
    acc_d   = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && last_item_i) begin
          state_d = S_RD;
          i_d     = '0;
          j_d     = '0;
          t_d     = '0;
          cov_d   = 1'b0;
          acc_d   = '0;
        end
      end
      S_RD:  state_d = S_CEN;
      S_CEN: state_d = S_MUL;
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        acc_d = acc_q + {{(AW - PW){prod_q[PW-1]}}, prod_q};
        if (t_last) begin
          state_d = S_DIV;
        end else begin
          t_d     = t_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_DIV: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_RD;
          t_d     = '0;
          acc_d   = '0;
          if (!cov_q) begin
            if (i_last) begin
              cov_d = 1'b1;
              i_d   = '0;
              j_d   = '0;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else if (j_last) begin
            j_d = '0;
            if (i_last) begin
              state_d = S_IDLE;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      t_q         <= '0;
      cov_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      t_q     <= t_d;
      cov_q   <= cov_d;
      acc_q   <= acc_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CEN) begin
      ci_q <= cov_q ? (xa - ma) : xa;
      cj_q <= cov_q ? (xb - mb) : CW'(1);
    end
    if (state_q == S_MUL) begin
      prod_q <= ci_q * cj_q;
    end
    if (state_q == S_DWAIT && div_done) begin
      res_q <= div_quot;
    end
    if (emit_fire) begin
      kind_q  <= cov_q ? sce_pkg::KIND_COV : sce_pkg::KIND_MEAN;
      row_q   <= 2'(i_q);
      col_q   <= cov_q ? 2'(j_q) : 2'd0;
      value_q <= cov_q ? res_q
               : {{(AW - VALUE_WIDTH){res_q[VALUE_WIDTH-1]}}, res_q[VALUE_WIDTH-1:0]};
      last_q  <= cov_q && i_last && j_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign row_index_o    = row_q;
  assign col_index_o    = col_q;
  assign result_value_o = value_q;
  assign last_result_o  = last_q;

`ifndef SYNTH
  a_last_is_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |-> result_kind_o == sce_pkg::KIND_COV)
    else $error("last result flagged on a mean");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DWAIT) else $error("divider finished outside wait step");
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result shown without an emit step");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// sample covariance engine: random and directed return matrices, checked
// against an in-bench mean and covariance predictor through a scoreboard
// ----------------------------------------------------------------------------
class cov_scoreboard;
  logic [23:0] samples [4][256];
  logic [2:0]  asset_cnt;
  logic [8:0]  num_samples;
  logic [69:0] pending [$];  // kind, row, col, value, last
  int          errors;
  int          checked;

  function new();
    asset_cnt   = sce_pkg::ASSET_CNT_RST;
    num_samples = sce_pkg::NUM_SAMPLES_RST;
    errors      = 0;
    checked     = 0;
    for (int a = 0; a < 4; a++) begin
      for (int s = 0; s < 256; s++) begin
        samples[a][s] = '0;
      end
    end
  endfunction

  function automatic longint div_toward_zero(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = mag / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function void note_request(logic [1:0] a, logic [7:0] s, logic [23:0] v, logic last);
    int     na;
    int     ns;
    longint acc;
    longint means [4];
    if (!last) begin
      samples[a][s] = v;
      return;
    end
    samples[a][s] = v;
    na = (asset_cnt < 1) ? 1 : (asset_cnt > 4) ? 4 : asset_cnt;
    ns = (num_samples < 2) ? 2 : (num_samples > 256) ? 256 : num_samples;
    for (int i = 0; i < na; i++) begin
      acc = 0;
      for (int t = 0; t < ns; t++) begin
        acc += longint'($signed(samples[i][t]));
      end
      // mean is stored back at value width
      means[i] = longint'($signed(24'(div_toward_zero(acc, ns))));
      pending.insert(pending.size(), {sce_pkg::KIND_MEAN, 2'(i), 2'd0, means[i], 1'b0});
    end
    for (int i = 0; i < na; i++) begin
      for (int j = 0; j < na; j++) begin
        acc = 0;
        for (int t = 0; t < ns; t++) begin
          acc += (longint'($signed(samples[i][t])) - means[i]) *
                 (longint'($signed(samples[j][t])) - means[j]);
        end
        pending.insert(pending.size(),
                       {sce_pkg::KIND_COV, 2'(i), 2'(j), div_toward_zero(acc, ns - 1),
                        1'(i == na - 1 && j == na - 1)});
      end
    end
  endfunction

  task report(string what, logic [69:0] got, logic [69:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task check_result(logic [69:0] got);
    logic [69:0] want;
    checked++;
    if (pending.size() == 0) begin
      report("unexpected result", got, '0);
      return;
    end
    want = pending.pop_front();
    if (got[69] !== want[69]) report("result_kind", got, want);
    if (got[68:67] !== want[68:67]) report("row_index", got, want);
    if (got[66:65] !== want[66:65]) report("col_index", got, want);
    if (got[64:1] !== want[64:1]) report("result_value", got, want);
    if (got[0] !== want[0]) report("last_result", got, want);
  endtask
endclass

module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  asset_index_i = '0;
  logic [7:0]  sample_index_i = '0;
  logic [23:0] return_value_i = '0;
  logic        last_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [1:0]  row_index_o;
  logic [1:0]  col_index_o;
  logic [63:0] result_value_o;
  logic        last_result_o;

  cov_scoreboard board = new();
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    cycles = 0;
  int    requests = 0;
  int    matrices = 0;
  int    cur_na = 4;
  int    cur_ns = 256;

  sample_covariance_engine i_dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result({result_kind_o, row_index_o, col_index_o, result_value_o,
                          last_result_o});
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // valid stays high between back-to-back requests; this task drops it only while idling
  task send_element(logic [1:0] a, logic [7:0] s, logic [23:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    asset_index_i  <= a;
    sample_index_i <= s;
    return_value_i <= v;
    last_item_i    <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(a, s, v, last);
    requests++;
  endtask

  task write_reg(logic idx, logic [8:0] val);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sce_pkg::CFG_ASSET_CNT) begin
      board.asset_cnt = val[2:0];
      cur_na = (val[2:0] < 1) ? 1 : (val[2:0] > 4) ? 4 : val[2:0];
    end else begin
      board.num_samples = val;
      cur_ns = (val < 2) ? 2 : (val > 256) ? 256 : val;
    end
  endtask

  // fill the configured window, mode 0 random, 1 all max, 2 all min
  task load_matrix(int mode);
    logic [23:0] v;
    for (int a = 0; a < cur_na; a++) begin
      for (int s = 0; s < cur_ns; s++) begin
        v = (mode == 1) ? 24'h7fffff : (mode == 2) ? 24'h800000 : 24'($urandom);
        if (mode == 0 && $urandom_range(3) == 0) v = 24'($signed(10'($urandom)));
        send_element(a[1:0], s[7:0], v, (a == cur_na - 1 && s == cur_ns - 1));
      end
    end
    matrices++;
  endtask

  task set_phase(int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: small sizes, extremes, clamping, elements outside the window
    write_reg(sce_pkg::CFG_ASSET_CNT, 9'd1);
    write_reg(sce_pkg::CFG_NUM_SAMPLES, 9'd2);
    load_matrix(1);
    load_matrix(2);
    write_reg(sce_pkg::CFG_ASSET_CNT, 9'd0);
    write_reg(sce_pkg::CFG_NUM_SAMPLES, 9'd0);
    send_element(2'd0, 8'd0, 24'h400000, 1'b0);
    send_element(2'd0, 8'd1, 24'hc00000, 1'b1);
    write_reg(sce_pkg::CFG_ASSET_CNT, 9'd7);
    write_reg(sce_pkg::CFG_NUM_SAMPLES, 9'd3);
    load_matrix(0);
    write_reg(sce_pkg::CFG_NUM_SAMPLES, 9'd33);
    write_reg(sce_pkg::CFG_ASSET_CNT, 9'd2);
    load_matrix(0);
    // element outside the window still stored, then last only triggers
    send_element(2'd3, 8'd255, 24'h123456, 1'b0);
    send_element(2'd1, 8'd255, 24'h7fffff, 1'b1);
    // random: small matrices under each idle and stall phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_phase(0, 0);
        1: set_phase(84, 0);
        2: set_phase(0, 84);
        default: set_phase(33, 33);
      endcase
      for (int m = 0; m < 3; m++) begin
        write_reg(sce_pkg::CFG_ASSET_CNT, 9'($urandom_range(4, 1)));
        write_reg(sce_pkg::CFG_NUM_SAMPLES, 9'($urandom_range(5, 2)));
        load_matrix(0);
      end
    end
    in_valid_i <= 1'b0;
    set_phase(0, 0);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests in %0d matrices, %0d results checked",
             requests, matrices, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/sce_pkg.sv
src/sce_ram.sv
src/sce_div.sv
src/sample_covariance_engine.sv
tb/sv/tb.sv
